[src/pnr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnr_pkg
// Shared types and constants for the polynomial Newton root finder.
// ----------------------------------------------------------------------------
package pnr_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_COEFS = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd7;

    localparam logic [1:0] OUT_CONVERGED = 2'd0;
    localparam logic [1:0] OUT_DERIV_ZERO = 2'd1;
    localparam logic [1:0] OUT_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DERIV,
        ST_CHECK,
        ST_EVAL,
        ST_TEST,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

[src/polynomial_newton_root.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_newton_root
// Newton iteration on a degree-5 polynomial in signed Q16.16.
// ----------------------------------------------------------------------------
// One guess is in flight at a time; busy is high from the edge that takes a
// guess until the result strobe. A guess begins with derivative setup, then
// iterates: a limit check, Horner steps on one shared multiplier, a tolerance
// test, the radix-2 divider and an update. A guess that converges or meets a
// zero derivative stops after the test; otherwise the iteration limit sets the
// length. The result is presented for one cycle on o_valid and must be
// captured then.
module polynomial_newton_root (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_guess,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_root_estimate,
    output logic [1:0]         o_outcome,
    output logic [7:0]         o_iterations_used
);
    import pnr_pkg::*;

    logic signed [31:0] r_coef [NUM_COEFS];
    logic signed [31:0] r_der  [NUM_COEFS-1];
    logic [30:0]        r_tol;
    logic [7:0]         r_lim;
    t_state             r_state, n_state;
    logic signed [31:0] r_x, r_f, r_fp, r_accf, r_accd;
    logic [7:0]         r_used;
    logic [2:0]         r_k;
    logic               r_ph;
    logic [1:0]         r_status;
    logic               w_div_start, w_div_done;
    logic signed [31:0] w_quot;
    logic signed [31:0] w_ma;
    logic signed [63:0] w_prod;
    logic signed [31:0] w_mul;
    logic signed [31:0] w_addc;
    logic signed [31:0] w_hres;
    logic [32:0]        w_af;
    logic signed [31:0] w_ck;
    logic signed [35:0] w_kc;

    assign o_cfg_ready = 1'b1;
    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) r_coef[i] <= '0;
            r_tol <= 31'd66;
            r_lim <= 8'd100;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TOLERANCE) r_tol <= i_cfg_data[30:0];
            else if (i_cfg_index == REG_ITER_LIMIT) r_lim <= i_cfg_data[7:0];
            else r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // k times coef_k by shift and add
    assign w_ck = r_coef[r_k];
    assign w_kc = (r_k[0] ? 36'(w_ck) : 36'sd0)
                + (r_k[1] ? (36'(w_ck) <<< 1) : 36'sd0)
                + (r_k[2] ? (36'(w_ck) <<< 2) : 36'sd0);

    // shared multiplier: horner step, phase 0 is f, phase 1 is f'
    assign w_ma   = r_ph ? r_accd : r_accf;
    assign w_prod = w_ma * r_x;
    assign w_mul  = sat32(66'(w_prod >>> FRAC_BITS));
    assign w_addc = r_ph ? r_der[r_k] : r_coef[r_k];
    assign w_hres = sat32(66'(w_mul) + 66'(w_addc));
    assign w_af   = r_f[31] ? 33'(-34'(r_f)) : 33'(r_f);

    pnr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_f),
        .i_den  (r_fp),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_DERIV;
            ST_DERIV:  if (r_k == 3'd5) n_state = ST_CHECK;
            ST_CHECK:  n_state = (r_used == r_lim) ? ST_DONE : ST_EVAL;
            ST_EVAL:   if (r_k == 3'd0 && r_ph) n_state = ST_TEST;
            ST_TEST: begin
                if (w_af < 33'(r_tol) || r_fp == '0) n_state = ST_DONE;
                else n_state = ST_DIV;
            end
            ST_DIV:    if (w_div_done) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_CHECK;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = (r_state == ST_TEST) && (n_state == ST_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x      <= i_start_guess;
                r_used   <= '0;
                r_k      <= 3'd1;
                r_status <= OUT_LIMIT;
            end
            ST_DERIV: begin
                r_der[r_k-3'd1] <= sat32(66'(w_kc));
                r_k <= r_k + 3'd1;
            end
            ST_CHECK: begin
                r_accf <= '0;
                r_accd <= '0;
                r_k    <= 3'd5;
                r_ph   <= 1'b0;
                r_status <= OUT_LIMIT;
            end
            ST_EVAL: begin
                if (!r_ph) begin
                    r_accf <= w_hres;
                    if (r_k == 3'd0) begin
                        r_f  <= w_hres;
                        r_ph <= 1'b1;
                        r_k  <= 3'd4;
                    end else begin
                        r_k <= r_k - 3'd1;
                    end
                end else begin
                    r_accd <= w_hres;
                    if (r_k == 3'd0) r_fp <= w_hres;
                    else r_k <= r_k - 3'd1;
                end
            end
            ST_TEST: begin
                if (w_af < 33'(r_tol)) r_status <= OUT_CONVERGED;
                else if (r_fp == '0) r_status <= OUT_DERIV_ZERO;
            end
            ST_UPDATE: begin
                r_x    <= sat32(66'(r_x) - 66'(w_quot));
                r_used <= r_used + 8'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            o_root_estimate   <= r_x;
            o_outcome         <= r_status;
            o_iterations_used <= r_used;
        end
    end
endmodule

[src/pnr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnr_div
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pnr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import pnr_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    logic [NW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [33:0]   w_trial;
    logic [32:0]   w_shift;
    logic [NW:0]   w_sq;

    assign w_shift = {r_rem[31:0], r_q[NW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), {FRAC_BITS{1'b0}}};
            r_den <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_rem <= '0;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign w_sq = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
    assign o_quot = sat32(66'(signed'(w_sq)));
endmodule

[tb/pnr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnr_checker
// Watches the guess, register and result channels of the Newton root finder,
// keeps its own copy of the registers, predicts each result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module pnr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_start_guess,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               o_valid,
    input  logic signed [31:0] o_root_estimate,
    input  logic [1:0]         o_outcome,
    input  logic [7:0]         o_iterations_used,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    import pnr_pkg::*;

    typedef struct packed {
        logic signed [31:0] root;
        logic [1:0]         outcome;
        logic [7:0]         iters;
    } t_root_result;

    logic signed [31:0] coef_q [NUM_COEFS];
    logic [30:0]        tol_q;
    logic [7:0]         limit_q;
    t_root_result       expected_roots [$];

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] horner(input logic signed [31:0] c [NUM_COEFS],
                                                 input int n,
                                                 input logic signed [31:0] x);
        logic signed [31:0] acc;
        acc = '0;
        for (int k = n - 1; k >= 0; k--)
            acc = clamp32(longint'(fx_mul(acc, x)) + longint'(c[k]));
        return acc;
    endfunction

    function automatic t_root_result solve_guess(input logic signed [31:0] guess);
        logic signed [31:0] slope_coef [NUM_COEFS];
        logic signed [31:0] x;
        logic signed [31:0] f;
        logic signed [31:0] fp;
        longint             af;
        longint             q;
        t_root_result       r;
        x = guess;
        r.outcome = OUT_LIMIT;
        r.iters = '0;
        slope_coef[NUM_COEFS-1] = '0;
        for (int k = 1; k < NUM_COEFS; k++)
            slope_coef[k-1] = clamp32(longint'(k) * longint'(coef_q[k]));
        for (int i = 0; i < limit_q; i++) begin
            f = horner(coef_q, NUM_COEFS, x);
            fp = horner(slope_coef, NUM_COEFS - 1, x);
            af = (f < 0) ? -longint'(f) : longint'(f);
            if (af < longint'({1'b0, tol_q})) begin
                r.outcome = OUT_CONVERGED;
                break;
            end
            if (fp == 0) begin
                r.outcome = OUT_DERIV_ZERO;
                break;
            end
            q = (longint'(f) <<< FRAC_BITS) / longint'(fp);
            x = clamp32(longint'(x) - longint'(clamp32(q)));
            r.iters = 8'(i + 1);
        end
        r.root = x;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_root_result exp_r;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) coef_q[k] <= '0;
            tol_q <= 31'd66;
            limit_q <= 8'd100;
            o_fail_count <= 0;
            o_pending <= 0;
            o_checked <= 0;
            expected_roots.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_TOLERANCE) tol_q <= i_cfg_data[30:0];
                else if (i_cfg_index == REG_ITER_LIMIT) limit_q <= i_cfg_data[7:0];
                else if (i_cfg_index < NUM_COEFS) coef_q[i_cfg_index] <= i_cfg_data;
            end
            if (start && !busy)
                expected_roots = {expected_roots, solve_guess(i_start_guess)};
            if (o_valid) begin
                if (expected_roots.size() == 0) begin
                    $error("result with no guess outstanding: root %0d", o_root_estimate);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_roots.pop_front();
                    o_checked <= o_checked + 1;
                    if (o_root_estimate !== exp_r.root
                        || o_outcome !== exp_r.outcome
                        || o_iterations_used !== exp_r.iters)
                        o_fail_count <= o_fail_count + 1;
                    if (o_root_estimate !== exp_r.root)
                        $error("root_estimate: expected %0d, got %0d",
                               exp_r.root, o_root_estimate);
                    if (o_outcome !== exp_r.outcome)
                        $error("outcome: expected %0d, got %0d", exp_r.outcome, o_outcome);
                    if (o_iterations_used !== exp_r.iters)
                        $error("iterations_used: expected %0d, got %0d",
                               exp_r.iters, o_iterations_used);
                end
            end
            o_pending <= expected_roots.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the polynomial Newton root finder: directed register settings
// and guesses first, then random polynomials, tolerances and iteration
// limits, with random gaps between guesses. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import pnr_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_start_guess = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [31:0] o_root_estimate;
    logic [1:0]         o_outcome;
    logic [7:0]         o_iterations_used;
    int                 fail_count;
    int                 pending;
    int                 checked;
    int                 cycle_count = 0;
    int                 guesses_sent = 0;
    int                 settings_used = 0;

    always #5 i_clk = ~i_clk;

    polynomial_newton_root dut (.*);

    pnr_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_poly(input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] c3,
                            input logic [31:0] c4, input logic [31:0] c5,
                            input logic [31:0] tol, input logic [31:0] lim);
        write_reg(REG_COEF_0, c0);
        write_reg(REG_COEF_1, c1);
        write_reg(REG_COEF_2, c2);
        write_reg(REG_COEF_3, c3);
        write_reg(REG_COEF_4, c4);
        write_reg(REG_COEF_5, c5);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_ITER_LIMIT, lim);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // busy only moves at rising edges, so it is sampled on the falling edge
    task automatic send_guess(input logic [31:0] guess);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_start_guess <= guess;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        guesses_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom();
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_guess();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_tol();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom();
            2: return 32'h7fffffff;
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    initial begin
        int lim;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero polynomial converges at once
        send_guess(32'h7fffffff);
        send_guess(32'h80000000);
        wait_idle();

        // no iterations allowed
        set_poly(32'h00010000, 0, 0, 0, 0, 0, 66, 0);
        send_guess(32'h12345678);
        send_guess(32'hfedcba98);
        wait_idle();

        // x^2 - 2 with the longest limit
        set_poly(32'hfffe0000, 0, 32'h00010000, 0, 0, 0, 66, 255);
        send_guess(32'h00010000);
        send_guess(32'hfffd0000);
        send_guess(32'h00000000);
        send_guess(32'h7fffffff);
        wait_idle();

        // constant nonzero: derivative zero
        set_poly(32'h7fffffff, 0, 0, 0, 0, 0, 66, 1);
        send_guess(32'h00050000);
        send_guess(32'h80000000);
        wait_idle();

        // zero tolerance never converges
        set_poly(32'hfffc0000, 0, 32'h00010000, 0, 0, 0, 0, 4);
        send_guess(32'h00030000);
        send_guess(32'h00020000);
        wait_idle();

        // extreme coefficients saturate everywhere, widest tolerance, then a tolerance of one
        set_poly(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff, 3);
        send_guess(32'h7fffffff);
        send_guess(32'h80000000);
        wait_idle();
        set_poly(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h00000001, 6);
        send_guess(32'h00008000);
        send_guess(32'hffff8000);
        send_guess(32'h00000001);
        wait_idle();

        // random phases, mostly short limits
        for (int phase = 0; phase < 13; phase++) begin
            lim = (phase == 6) ? 255 : $urandom_range(1, 14);
            set_poly(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), rand_tol(), lim);
            for (int n = 0; n < ((lim > 100) ? 6 : 50); n++) send_guess(rand_guess());
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        $display("sent %0d guesses over %0d register settings, %0d results checked",
                 guesses_sent, settings_used, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
